// File: src/assert_macros.svh
// Assertion macros used by the prefix autocomplete RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds at every clock edge outside reset
`define AM_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

// ante implies cons in the same cycle
`define AM_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

// File: src/prfx_pkg.sv
// Types, constants and helper functions of the prefix autocomplete table.
package prfx_pkg;

  localparam int TEXT_W        = 192;
  localparam int TEXT_BYTES    = 24;
  localparam int LEN_W         = 5;
  localparam int IDX_OUT_W     = 6;
  localparam int KEY_W         = TEXT_W + LEN_W;
  localparam int ENTRIES_DEF   = 64;
  localparam int MAX_BYTES_DEF = 21;
  localparam int COUNT_W_DEF   = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUEST = 8'h3F;

  typedef struct packed {
    logic        cmd;
    logic [63:0] text_bytes_a;
    logic [63:0] text_bytes_b;
    logic [63:0] text_bytes_c;
    logic [4:0]  text_length;
    logic        marked;
  } token_t;

  typedef struct packed {
    logic [63:0] reply_bytes_a;
    logic [63:0] reply_bytes_b;
    logic [63:0] reply_bytes_c;
    logic [4:0]  reply_length;
    logic        hit;
    logic        appended;
    logic        table_full;
    logic [5:0]  entry_index;
  } reply_t;

  typedef enum logic [3:0] {
    OP_LOAD   = 4'b0001,
    OP_ECHO   = 4'b0010,
    OP_EXACT  = 4'b0100,
    OP_PREFIX = 4'b1000
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [TEXT_W-1:0] text;
    logic [LEN_W-1:0]  len;
    logic [TEXT_W-1:0] mask;
  } work_t;

  function automatic logic [TEXT_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [TEXT_W-1:0] m;
    for (int i = 0; i < TEXT_BYTES; i++) begin
      m[i*8 +: 8] = (i < int'(len)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // first byte most significant, length last: prefix orders before longer word
  function automatic logic [KEY_W-1:0] order_key(input logic [TEXT_W-1:0] text,
                                                 input logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] k;
    for (int i = 0; i < TEXT_BYTES; i++) begin
      k[KEY_W-1-8*i -: 8] = text[i*8 +: 8];
    end
    k[LEN_W-1:0] = len;
    return k;
  endfunction

endpackage

// File: src/prfx_front.sv
// Front end: clamps and masks the token and classifies the item.
module prfx_front #(
  parameter int MAX_BYTES = prfx_pkg::MAX_BYTES_DEF
) (
  input  prfx_pkg::token_t token,
  output prfx_pkg::work_t  work
);

  logic [prfx_pkg::LEN_W-1:0]  len;
  logic [prfx_pkg::TEXT_W-1:0] mask;
  logic [prfx_pkg::TEXT_W-1:0] text;
  logic [7:0]                  first;
  logic                        punct;

  always_comb begin
    len = (token.text_length > prfx_pkg::LEN_W'(MAX_BYTES)) ?
          prfx_pkg::LEN_W'(MAX_BYTES) : token.text_length;
    mask  = prfx_pkg::byte_mask(len);
    text  = {token.text_bytes_c, token.text_bytes_b, token.text_bytes_a} & mask;
    first = text[7:0];
    punct = (first == prfx_pkg::CH_COMMA) || (first == prfx_pkg::CH_DOT) ||
            (first == prfx_pkg::CH_COLON) || (first == prfx_pkg::CH_BANG) ||
            (first == prfx_pkg::CH_QUEST);
    work.text = text;
    work.len  = len;
    work.mask = mask;
    if (!token.cmd) begin
      work.op = prfx_pkg::OP_LOAD;
    end else if (!token.marked && len == prfx_pkg::LEN_W'(1) && punct) begin
      work.op = prfx_pkg::OP_ECHO;
    end else if (token.marked) begin
      work.op = prfx_pkg::OP_EXACT;
    end else begin
      work.op = prfx_pkg::OP_PREFIX;
    end
  end

endmodule

// File: src/prfx_queue.sv
// Short item queue between front end and table engine.
module prfx_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  prfx_pkg::work_t wdata,
  output logic            full,
  input  logic            pop,
  output prfx_pkg::work_t rdata,
  output logic            empty
);

  localparam int PW = $clog2(prfx_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(prfx_pkg::QUEUE_DEPTH + 1);

  prfx_pkg::work_t slots [prfx_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = count == CW'(prfx_pkg::QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(prfx_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(prfx_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// File: src/prfx_engine.sv
// Table engine: scans the word table for lookups, picks the match and updates or appends entries.
`include "assert_macros.svh"
module prfx_engine #(
  parameter int ENTRIES     = prfx_pkg::ENTRIES_DEF,
  parameter int COUNT_WIDTH = prfx_pkg::COUNT_W_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  prfx_pkg::work_t  q_data,
  output logic             q_pop,
  output prfx_pkg::reply_t reply,
  output logic             empty,
  input  logic             pop
);

  localparam int IW    = $clog2(ENTRIES);
  localparam int UW    = $clog2(ENTRIES + 1);
  localparam int TW    = prfx_pkg::TEXT_W;
  localparam int LW    = prfx_pkg::LEN_W;
  localparam int ROW_W = TW + LW + COUNT_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  logic [ROW_W-1:0] mem [ENTRIES];

  state_t                 state;
  prfx_pkg::work_t        cur;
  logic [UW-1:0]          used;
  logic [UW-1:0]          issue;
  logic                   rd_vld;
  logic [IW-1:0]          rd_idx;
  logic [ROW_W-1:0]       rd_row;
  logic                   found;
  logic [IW-1:0]          best_idx;
  logic [TW-1:0]          best_text;
  logic [LW-1:0]          best_len;
  logic [COUNT_WIDTH-1:0] best_cnt;
  logic                   out_vld;

  logic                   rd_en;
  logic [TW-1:0]          r_text;
  logic [LW-1:0]          r_len;
  logic [COUNT_WIDTH-1:0] r_cnt;
  logic                   exact;
  logic                   pref;
  logic                   better;
  logic                   take;
  logic                   out_free;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [ROW_W-1:0]       wr_row;
  logic                   grow;
  prfx_pkg::reply_t       res;
  logic [TW-1:0]          res_text;
  logic [COUNT_WIDTH-1:0] sat_cnt;

  assign empty    = !out_vld;
  assign out_free = !out_vld || pop;
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign rd_en    = (state == S_SCAN) && (issue < used);

  assign r_text = rd_row[ROW_W-1 -: TW];
  assign r_len  = rd_row[COUNT_WIDTH +: LW];
  assign r_cnt  = rd_row[COUNT_WIDTH-1:0];

  always_comb begin
    exact  = (r_len == cur.len) && (r_text == cur.text);
    pref   = (r_len >= cur.len) && ((r_text & cur.mask) == cur.text);
    better = !found || (r_cnt > best_cnt) ||
             ((r_cnt == best_cnt) &&
              (prfx_pkg::order_key(r_text, r_len) <
               prfx_pkg::order_key(best_text, best_len)));
    take   = rd_vld && ((cur.op == prfx_pkg::OP_EXACT) ? (exact && !found)
                                                       : (pref && better));
  end

  always_comb begin
    sat_cnt  = (best_cnt == '1) ? best_cnt : best_cnt + COUNT_WIDTH'(1);
    res_text = cur.text;
    wr_en    = 1'b0;
    wr_addr  = used[IW-1:0];
    wr_row   = {cur.text, cur.len, COUNT_WIDTH'(1)};
    grow     = 1'b0;
    res.reply_length = cur.len;
    res.hit          = 1'b0;
    res.appended     = 1'b0;
    res.table_full   = 1'b0;
    res.entry_index  = '0;
    if (cur.op == prfx_pkg::OP_LOAD) begin
      wr_row = {cur.text, cur.len, COUNT_WIDTH'(0)};
    end
    if ((cur.op == prfx_pkg::OP_EXACT || cur.op == prfx_pkg::OP_PREFIX) && found) begin
      wr_en           = 1'b1;
      wr_addr         = best_idx;
      wr_row          = {best_text, best_len, sat_cnt};
      res.hit         = 1'b1;
      res.entry_index = prfx_pkg::IDX_OUT_W'(best_idx);
      if (cur.op == prfx_pkg::OP_PREFIX) begin
        res_text         = best_text;
        res.reply_length = best_len;
      end
    end else if (cur.op != prfx_pkg::OP_ECHO) begin
      if (used == UW'(ENTRIES)) begin
        res.table_full = 1'b1;
      end else begin
        wr_en           = 1'b1;
        grow            = 1'b1;
        res.appended    = 1'b1;
        res.entry_index = prfx_pkg::IDX_OUT_W'(used);
      end
    end
    res.reply_bytes_a = res_text[63:0];
    res.reply_bytes_b = res_text[127:64];
    res.reply_bytes_c = res_text[191:128];
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[issue[IW-1:0]];
    end
    if (state == S_WRITE && out_free && wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (rd_en) begin
      rd_idx <= issue[IW-1:0];
    end
    if (take) begin
      best_idx  <= rd_idx;
      best_text <= r_text;
      best_len  <= r_len;
      best_cnt  <= r_cnt;
    end
    if (state == S_WRITE && out_free) begin
      reply <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      used    <= '0;
      issue   <= '0;
      rd_vld  <= 1'b0;
      found   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (state == S_WRITE && out_free) begin
        out_vld <= 1'b1;
      end else if (pop) begin
        out_vld <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            issue  <= '0;
            rd_vld <= 1'b0;
            found  <= 1'b0;
            if (q_data.op == prfx_pkg::OP_EXACT || q_data.op == prfx_pkg::OP_PREFIX) begin
              state <= S_SCAN;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_SCAN: begin
          rd_vld <= rd_en;
          if (rd_en) begin
            issue <= issue + UW'(1);
          end else begin
            state <= S_WRITE;
          end
          if (take) begin
            found <= 1'b1;
          end
        end
        S_WRITE: begin
          rd_vld <= 1'b0;
          if (out_free) begin
            if (grow) begin
              used <= used + UW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `AM_ALWAYS(a_used_bound, clk, rst, used <= UW'(ENTRIES))
  `AM_IMPLY(a_hit_xor_append, clk, rst, out_vld, !(reply.hit && reply.appended))
  `AM_IMPLY(a_full_only_when_full, clk, rst, out_vld && reply.table_full, used == UW'(ENTRIES))
  `AM_IMPLY(a_scan_in_range, clk, rst, state == S_SCAN, issue <= used)

endmodule

// File: src/prfx_autocomplete_table_unit.sv
// Top level of the frequency-ranked prefix autocomplete table.
// A load or a punctuation token goes from the queue straight to the write
// state; a marked or unmarked token first scans every entry in use through
// the table memory's single read port, one entry per cycle. A two-item
// queue after the input classifier and a result register let the input and
// output sides stall independently of the table engine.
module prefix_autocomplete_table_unit #(
  parameter int ENTRIES     = prfx_pkg::ENTRIES_DEF,
  parameter int MAX_BYTES   = prfx_pkg::MAX_BYTES_DEF,
  parameter int COUNT_WIDTH = prfx_pkg::COUNT_W_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  prfx_pkg::token_t token,
  output logic             empty,
  input  logic             pop,
  output prfx_pkg::reply_t reply
);

  prfx_pkg::work_t work;
  prfx_pkg::work_t q_data;
  logic            q_empty;
  logic            q_pop;

  prfx_front #(
    .MAX_BYTES(MAX_BYTES)
  ) u_front (
    .token(token),
    .work (work)
  );

  prfx_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(work),
    .full (full),
    .pop  (q_pop),
    .rdata(q_data),
    .empty(q_empty)
  );

  prfx_engine #(
    .ENTRIES    (ENTRIES),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .q_empty(q_empty),
    .q_data (q_data),
    .q_pop  (q_pop),
    .reply  (reply),
    .empty  (empty),
    .pop    (pop)
  );

endmodule
